// File: rtl/pci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pci_pkg
// Widths, payload types and saturation helpers for the perspective-correct
// barycentric interpolator.
// ----------------------------------------------------------------------------
package pci_pkg;

  localparam int WGT_W   = 16;
  localparam int RW_W    = 24;
  localparam int ATTR_W  = 32;
  localparam int SUM_W   = 24;
  localparam int DEPTH_W = 32;
  localparam int PROD_W  = WGT_W + RW_W;     // weight * recip w, Q9.31
  localparam int Q_W     = 26;               // rescaled product, Q10.16
  localparam int T_W     = 17;               // rescaled weight, Q1.16
  localparam int AFP_W   = 48;               // attr * weight
  localparam int PAP_W   = 50;               // attr * rescaled weight
  localparam int WIDE_W  = 52;
  localparam int DIV_STEPS = DEPTH_W + 1;    // quotient bits of 2^32 / sum

  localparam int IN_DATA_W  = 216;
  localparam int OUT_DATA_W = 120;

  localparam logic [T_W-1:0]     T_MAX     = '1;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  // payload that rides through the divider
  typedef struct packed {
    logic [SUM_W-1:0]             sum;
    logic                         tiny;
    logic [ATTR_W-1:0]            affine;
    logic [2:0][Q_W-1:0]          q;
    logic [2:0][ATTR_W-1:0]       attr;
  } div_pl_t;

  // payload of the tail stages
  typedef struct packed {
    logic [SUM_W-1:0]             sum;
    logic [DEPTH_W-1:0]           depth;
    logic [ATTR_W-1:0]            affine;
    logic                         flag;
  } tail_pl_t;

  function automatic logic [ATTR_W-1:0] sat_s32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(signed'(33'sh07FFFFFFF));
    lo = WIDE_W'(signed'(33'sh180000000));
    if (v > hi) begin
      sat_s32 = 32'h7FFFFFFF;
    end else if (v < lo) begin
      sat_s32 = 32'h80000000;
    end else begin
      sat_s32 = v[ATTR_W-1:0];
    end
  endfunction

endpackage

// File: rtl/perspective_correct_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_correct_interpolator
// Per-pixel perspective-correct and affine interpolation of one attribute.
// ----------------------------------------------------------------------------
// divider: the 33-step restoring divider forms 2^32 / sum, one quotient
//   bit per stage
// throughput: one request per cycle while the skid is empty; a one-entry
//   skid after the output register lets one more result finish on a stall
// reset: synchronous active-low rst_n clears all valid bits, no clearing pass
module perspective_correct_interpolator
  import pci_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // weight_a, weight_b, weight_c, recip_w_a, recip_w_b, recip_w_c,
  // attr_a, attr_b, attr_c
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // recip_w_sum, pixel_depth, persp_attr, affine_attr
  output logic [OUT_DATA_W-1:0] out_tdata,
  // depth_saturated
  output logic                  out_tuser
);

  logic run;
  assign run = in_tready;

  // -------- unpack
  logic [2:0][WGT_W-1:0]  in_w;
  logic [2:0][RW_W-1:0]   in_rw;
  logic [2:0][ATTR_W-1:0] in_attr;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_w[i]    = in_tdata[i*WGT_W +: WGT_W];
      in_rw[i]   = in_tdata[3*WGT_W + i*RW_W +: RW_W];
      in_attr[i] = in_tdata[3*WGT_W + 3*RW_W + i*ATTR_W +: ATTR_W];
    end
  end

  // -------- stage 1: products
  logic                         v1_r;
  logic [2:0][PROD_W-1:0]       p1_r;
  logic [2:0][AFP_W-1:0]        ap1_r;
  logic [2:0][ATTR_W-1:0]       attr1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (run) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i]    <= PROD_W'(in_w[i]) * PROD_W'(in_rw[i]);
        ap1_r[i]   <= AFP_W'(signed'(AFP_W'(signed'(in_attr[i])) *
                       AFP_W'(signed'({1'b0, in_w[i]}))));
        attr1_r[i] <= in_attr[i];
      end
    end
  end

  // -------- stage 2: sums, rounding
  logic [PROD_W+1:0]        acc;
  logic [PROD_W-14:0]       sum_raw;
  logic [SUM_W-1:0]         sum_sat;
  logic signed [AFP_W+1:0]  af_acc;
  logic signed [WIDE_W-1:0] af_rnd;
  div_pl_t                  pl2_nxt;
  logic                     v2_r;
  div_pl_t                  pl2_r;

  always_comb begin
    acc     = (PROD_W+2)'(p1_r[0]) + (PROD_W+2)'(p1_r[1]) + (PROD_W+2)'(p1_r[2]);
    sum_raw = (PROD_W-13)'((acc + (PROD_W+2)'(1 << 14)) >> 15);
    sum_sat = (sum_raw > (PROD_W-13)'({SUM_W{1'b1}})) ? '1 : sum_raw[SUM_W-1:0];
    af_acc  = (AFP_W+2)'(signed'(ap1_r[0])) + (AFP_W+2)'(signed'(ap1_r[1]))
            + (AFP_W+2)'(signed'(ap1_r[2]));
    af_rnd  = WIDE_W'((af_acc + (AFP_W+2)'(1 << 14)) >>> 15);
    pl2_nxt.sum    = sum_sat;
    pl2_nxt.tiny   = (sum_sat <= SUM_W'(1));
    pl2_nxt.affine = sat_s32(af_rnd);
    pl2_nxt.attr   = attr1_r;
    for (int i = 0; i < 3; i++) begin
      pl2_nxt.q[i] = Q_W'((PROD_W+1)'(p1_r[i]) + (PROD_W+1)'(1 << 14) >> 15);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (run) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      pl2_r <= pl2_nxt;
    end
  end

  // -------- divider: one quotient bit per stage
  logic                 dv_v_r   [DIV_STEPS];
  logic [SUM_W-1:0]     dv_rem_r [DIV_STEPS];
  logic [DEPTH_W-1:0]   dv_quo_r [DIV_STEPS];
  div_pl_t              dv_pl_r  [DIV_STEPS];

  genvar k;
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_div
      logic               v_in;
      logic [SUM_W-1:0]   rem_in;
      logic [DEPTH_W-1:0] quo_in;
      div_pl_t            pl_in;
      logic [SUM_W:0]     rem_sh;
      logic [SUM_W+1:0]   diff;
      logic               ge;

      if (k == 0) begin : g_first
        assign v_in   = v2_r;
        assign rem_in = '0;
        assign quo_in = '0;
        assign pl_in  = pl2_r;
      end else begin : g_next
        assign v_in   = dv_v_r[k-1];
        assign rem_in = dv_rem_r[k-1];
        assign quo_in = dv_quo_r[k-1];
        assign pl_in  = dv_pl_r[k-1];
      end

      // dividend 2^32 has its only set bit in the first step
      assign rem_sh = {rem_in, (k == 0) ? 1'b1 : 1'b0};
      assign diff   = {1'b0, rem_sh} - {2'b00, pl_in.sum};
      assign ge     = !diff[SUM_W+1];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          dv_v_r[k] <= 1'b0;
        end else if (run) begin
          dv_v_r[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (run) begin
          dv_rem_r[k] <= ge ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
          dv_quo_r[k] <= {quo_in[DEPTH_W-2:0], ge};
          dv_pl_r[k]  <= pl_in;
        end
      end
    end
  endgenerate

  // -------- stage m: q_i * depth
  localparam int MP_W = Q_W + DEPTH_W;
  logic [DEPTH_W-1:0]         depth;
  logic                       vm_r;
  logic [2:0][MP_W-1:0]       mp_r;
  logic [2:0][ATTR_W-1:0]     attrm_r;
  tail_pl_t                   tlm_r;

  assign depth = dv_pl_r[DIV_STEPS-1].tiny ? DEPTH_MAX : dv_quo_r[DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (run) begin
      vm_r <= dv_v_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      for (int i = 0; i < 3; i++) begin
        mp_r[i] <= MP_W'(dv_pl_r[DIV_STEPS-1].q[i]) * MP_W'(depth);
      end
      attrm_r       <= dv_pl_r[DIV_STEPS-1].attr;
      tlm_r.sum     <= dv_pl_r[DIV_STEPS-1].sum;
      tlm_r.depth   <= depth;
      tlm_r.affine  <= dv_pl_r[DIV_STEPS-1].affine;
      tlm_r.flag    <= dv_pl_r[DIV_STEPS-1].tiny;
    end
  end

  // -------- stage t: round and clamp rescaled weights
  logic [2:0][MP_W-16:0]      tv;
  logic                       vt_r;
  logic [2:0][T_W-1:0]        t_r;
  logic [2:0][ATTR_W-1:0]     attrt_r;
  tail_pl_t                   tlt_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tv[i] = (MP_W-15)'(((MP_W+1)'(mp_r[i]) + (MP_W+1)'(1 << 15)) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r <= 1'b0;
    end else if (run) begin
      vt_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      for (int i = 0; i < 3; i++) begin
        t_r[i] <= (tv[i] > (MP_W-15)'(T_MAX)) ? T_MAX : tv[i][T_W-1:0];
      end
      attrt_r <= attrm_r;
      tlt_r   <= tlm_r;
    end
  end

  // -------- stage a: attr * t
  logic                       va_r;
  logic [2:0][PAP_W-1:0]      pa_r;
  tail_pl_t                   tla_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (run) begin
      va_r <= vt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= PAP_W'(signed'(PAP_W'(signed'(attrt_r[i])) *
                   PAP_W'(signed'({1'b0, t_r[i]}))));
      end
      tla_r <= tlt_r;
    end
  end

  // -------- final sum, output register and skid
  logic signed [PAP_W+1:0]    ps_acc;
  logic signed [WIDE_W-1:0]   ps_rnd;
  logic [OUT_DATA_W-1:0]      res_data;
  logic                       push;
  logic                       pop;
  logic                       out_v_r;
  logic [OUT_DATA_W-1:0]      out_data_r;
  logic                       out_flag_r;
  logic                       skid_v_r;
  logic [OUT_DATA_W-1:0]      skid_data_r;
  logic                       skid_flag_r;

  always_comb begin
    ps_acc   = (PAP_W+2)'(signed'(pa_r[0])) + (PAP_W+2)'(signed'(pa_r[1]))
             + (PAP_W+2)'(signed'(pa_r[2]));
    ps_rnd   = WIDE_W'((ps_acc + (PAP_W+2)'(1 << 15)) >>> 16);
    res_data = {tla_r.affine, sat_s32(ps_rnd), tla_r.depth, tla_r.sum};
  end

  assign push = run && va_r;
  assign pop  = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (out_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
        out_flag_r <= skid_flag_r;
      end
    end else if (push) begin
      if (out_v_r && !pop) begin
        skid_data_r <= res_data;
        skid_flag_r <= tla_r.flag;
      end else begin
        out_data_r <= res_data;
        out_flag_r <= tla_r.flag;
      end
    end
  end

  assign in_tready  = !skid_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;

`ifndef SYNTHESIS
  a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a result while output register is empty");

  a_flag_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[55:24] == DEPTH_MAX &&
                                   out_tdata[23:0] <= 24'd1))
    else $error("saturated depth flag without saturated depth");

  a_noflag_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[23:0] > 24'd1))
    else $error("unsaturated depth with sum below two");
`endif

endmodule
